FILE: sv/lswc_pkg.sv
// ----------------------------------------------------------------------------
// lswc_pkg: shared types and constants for the line segment window clipper
// Holds the configuration register indexes and the window reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lswc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_LEFT   = 2'd0,
        CFG_WIN_BOTTOM = 2'd1,
        CFG_WIN_RIGHT  = 2'd2,
        CFG_WIN_TOP    = 2'd3
    } t_cfg_idx;

    // Window reset values
    localparam int WIN_LEFT_RST   = 0;
    localparam int WIN_BOTTOM_RST = 0;
    localparam int WIN_RIGHT_RST  = 639;
    localparam int WIN_TOP_RST    = 479;

    // Boundary count: left, right, bottom, top
    localparam int NUM_BND = 4;

endpackage

`default_nettype wire

FILE: sv/line_segment_window_clipper_top.sv
// ----------------------------------------------------------------------------
// line_segment_window_clipper_top: parametric four-boundary segment clipper
// Clips one segment per cycle against a window held in config registers.
// ----------------------------------------------------------------------------
// Usage:
//   A request (start_x/y, end_x/y) is taken at each rising edge where start
//   is high and busy is low. busy stays low: a new request may come in every
//   cycle and all requests in flight move through the pipeline together.
//   The window registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
//   and must only change while no request is in flight.
//   Each result appears for one cycle with o_valid high. Throughput is
//   one segment per cycle. After stage A comes the restoring divider,
//   which resolves one quotient bit per stage for all four boundaries in
//   parallel; then come the signed ratio stage, the entry/exit update
//   (two stages), one multiply stage and the rounding/output stage.
//   Rejected segments give o_visible low and all-zero coordinates.
//   Reset (synchronous, active low) empties the pipeline and loads the
//   default window 0..639 by 0..479. The receiver cannot hold results off.
// ----------------------------------------------------------------------------
`default_nettype none

module line_segment_window_clipper_top #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request channel
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [COORD_WIDTH-1:0]        i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_end_y,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [lswc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0]               i_cfg_data,
    // result channel
    output logic                                      o_valid,
    output logic                                      o_visible,
    output logic signed [COORD_WIDTH-1:0]             o_clip_start_x,
    output logic signed [COORD_WIDTH-1:0]             o_clip_start_y,
    output logic signed [COORD_WIDTH-1:0]             o_clip_end_x,
    output logic signed [COORD_WIDTH-1:0]             o_clip_end_y
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = CW + 1;          // difference / magnitude width
    localparam int TW = F + 3;           // signed ratio, holds +-2.0
    localparam int PW = F + MW + 1;      // product width
    localparam int NB = lswc_pkg::NUM_BND;

    localparam logic signed [TW-1:0] T_ONE  = TW'(1) << F;
    localparam logic        [F+1:0]  M_SAT  = (F+2)'(2) << F;
    localparam logic        [PW-1:0] P_HALF = PW'(1) << (F - 1);

    typedef struct packed {
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
        logic signed [MW-1:0] dx;
        logic signed [MW-1:0] dy;
        logic                 rej;
        logic [NB-1:0]        zp;
        logic [NB-1:0]        negp;
        logic [NB-1:0]        negt;
        logic [NB-1:0]        sat;
    } t_meta;

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Window registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_win_left, r_win_bottom, r_win_right, r_win_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= CW'(lswc_pkg::WIN_LEFT_RST);
            r_win_bottom <= CW'(lswc_pkg::WIN_BOTTOM_RST);
            r_win_right  <= CW'(lswc_pkg::WIN_RIGHT_RST);
            r_win_top    <= CW'(lswc_pkg::WIN_TOP_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lswc_pkg::CFG_WIN_LEFT:   r_win_left   <= i_cfg_data;
                lswc_pkg::CFG_WIN_BOTTOM: r_win_bottom <= i_cfg_data;
                lswc_pkg::CFG_WIN_RIGHT:  r_win_right  <= i_cfg_data;
                lswc_pkg::CFG_WIN_TOP:    r_win_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: deltas, boundary directions p and distances q
    // ------------------------------------------------------------------
    logic                 r_a_vld;
    logic signed [CW-1:0] r_a_x1, r_a_y1;
    logic signed [MW-1:0] r_a_dx, r_a_dy;
    logic signed [MW-1:0] r_a_p [0:NB-1];
    logic signed [MW-1:0] r_a_q [0:NB-1];

    logic signed [MW-1:0] n_dx, n_dy, x1_e, y1_e;

    always_comb begin
        x1_e = {i_start_x[CW-1], i_start_x};
        y1_e = {i_start_y[CW-1], i_start_y};
        n_dx = {i_end_x[CW-1], i_end_x} - x1_e;
        n_dy = {i_end_y[CW-1], i_end_y} - y1_e;
    end

    always_ff @(posedge i_clk) begin
        r_a_x1   <= i_start_x;
        r_a_y1   <= i_start_y;
        r_a_dx   <= n_dx;
        r_a_dy   <= n_dy;
        r_a_p[0] <= -n_dx;
        r_a_q[0] <= x1_e - {r_win_left[CW-1], r_win_left};
        r_a_p[1] <= n_dx;
        r_a_q[1] <= {r_win_right[CW-1], r_win_right} - x1_e;
        r_a_p[2] <= -n_dy;
        r_a_q[2] <= y1_e - {r_win_bottom[CW-1], r_win_bottom};
        r_a_p[3] <= n_dy;
        r_a_q[3] <= {r_win_top[CW-1], r_win_top} - y1_e;
    end

    // ------------------------------------------------------------------
    // Divider: stage 0 sets the integer part, stages 1..F one bit each
    // ------------------------------------------------------------------
    logic [F:0]    r_d_vld;
    t_meta         r_meta [0:F];
    logic [MW-1:0] r_rem  [0:F][0:NB-1];
    logic [MW-1:0] r_ap   [0:F][0:NB-1];
    logic [F:0]    r_frac [0:F][0:NB-1];

    t_meta         n_meta0;
    logic [MW-1:0] n_rem0  [0:NB-1];
    logic [MW-1:0] n_ap0   [0:NB-1];
    logic [F:0]    n_frac0 [0:NB-1];

    always_comb begin
        logic [MW-1:0] aq, ap;
        logic          iq;
        n_meta0.x1  = r_a_x1;
        n_meta0.y1  = r_a_y1;
        n_meta0.dx  = r_a_dx;
        n_meta0.dy  = r_a_dy;
        n_meta0.rej = 1'b0;
        for (int b = 0; b < NB; b++) begin
            aq = r_a_q[b][MW-1] ? MW'(-r_a_q[b]) : MW'(r_a_q[b]);
            ap = r_a_p[b][MW-1] ? MW'(-r_a_p[b]) : MW'(r_a_p[b]);
            iq = (aq >= ap);
            n_meta0.zp[b]   = (ap == '0);
            n_meta0.negp[b] = r_a_p[b][MW-1];
            n_meta0.negt[b] = r_a_q[b][MW-1] ^ r_a_p[b][MW-1];
            n_meta0.sat[b]  = ({1'b0, aq} >= {ap, 1'b0});
            // parallel to this boundary and outside it
            if (ap == '0 && r_a_q[b][MW-1])
                n_meta0.rej = 1'b1;
            n_rem0[b]  = iq ? aq - ap : aq;
            n_ap0[b]   = ap;
            n_frac0[b] = {{F{1'b0}}, iq};
        end
    end

    // one restoring step per stage
    logic [MW-1:0] n_rem  [1:F][0:NB-1];
    logic [F:0]    n_frac [1:F][0:NB-1];

    always_comb begin
        logic [MW:0] rem2;
        logic        ge;
        for (int s = 1; s <= F; s++) begin
            for (int b = 0; b < NB; b++) begin
                rem2 = {r_rem[s-1][b], 1'b0};
                ge   = (rem2 >= {1'b0, r_ap[s-1][b]});
                n_rem[s][b]  = ge ? MW'(rem2 - {1'b0, r_ap[s-1][b]}) : rem2[MW-1:0];
                n_frac[s][b] = {r_frac[s-1][b][F-1:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta[0] <= n_meta0;
        for (int b = 0; b < NB; b++) begin
            r_rem[0][b]  <= n_rem0[b];
            r_ap[0][b]   <= n_ap0[b];
            r_frac[0][b] <= n_frac0[b];
        end
        for (int s = 1; s <= F; s++) begin
            r_meta[s] <= r_meta[s-1];
            for (int b = 0; b < NB; b++) begin
                r_rem[s][b]  <= n_rem[s][b];
                r_ap[s][b]   <= r_ap[s-1][b];
                r_frac[s][b] <= n_frac[s][b];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage T: signed, saturated ratio per boundary
    // ------------------------------------------------------------------
    logic                 r_t_vld;
    t_meta                r_t_meta;
    logic signed [TW-1:0] r_t_t [0:NB-1];

    always_ff @(posedge i_clk) begin
        logic [F+1:0] m;
        r_t_meta <= r_meta[F];
        for (int b = 0; b < NB; b++) begin
            m = r_meta[F].sat[b] ? M_SAT : {1'b0, r_frac[F][b]};
            r_t_t[b] <= r_meta[F].negt[b] ? -TW'(m) : TW'(m);
        end
    end

    // ------------------------------------------------------------------
    // Stages C1/C2: entry/exit update (left, right) then (bottom, top)
    // ------------------------------------------------------------------
    typedef struct packed {
        logic                 ok;
        logic signed [TW-1:0] t0;
        logic signed [TW-1:0] t1;
    } t_win;

    function automatic t_win bnd_update(input t_win w, input logic zp, input logic negp,
                                        input logic signed [TW-1:0] t);
        t_win r;
        r = w;
        if (!zp) begin
            if (negp) begin
                if (t > w.t1)      r.ok = 1'b0;
                else if (t > w.t0) r.t0 = t;
            end else begin
                if (t < w.t0)      r.ok = 1'b0;
                else if (t < w.t1) r.t1 = t;
            end
        end
        return r;
    endfunction

    logic                 r_c1_vld;
    t_meta                r_c1_meta;
    t_win                 r_c1_w;
    logic signed [TW-1:0] r_c1_tb, r_c1_tt;
    logic                 r_c2_vld;
    t_meta                r_c2_meta;
    t_win                 r_c2_w;

    t_win n_c1_w, n_c2_w;

    always_comb begin
        t_win w;
        w.ok = !r_t_meta.rej;
        w.t0 = '0;
        w.t1 = T_ONE;
        w = bnd_update(w, r_t_meta.zp[0], r_t_meta.negp[0], r_t_t[0]);
        n_c1_w = bnd_update(w, r_t_meta.zp[1], r_t_meta.negp[1], r_t_t[1]);
    end

    always_comb begin
        t_win w;
        w = bnd_update(r_c1_w, r_c1_meta.zp[2], r_c1_meta.negp[2], r_c1_tb);
        n_c2_w = bnd_update(w, r_c1_meta.zp[3], r_c1_meta.negp[3], r_c1_tt);
    end

    always_ff @(posedge i_clk) begin
        r_c1_meta <= r_t_meta;
        r_c1_w    <= n_c1_w;
        r_c1_tb   <= r_t_t[2];
        r_c1_tt   <= r_t_t[3];
        r_c2_meta <= r_c1_meta;
        r_c2_w    <= n_c2_w;
    end

    // ------------------------------------------------------------------
    // Stage M: |d| * t for both endpoints and both axes
    // ------------------------------------------------------------------
    logic              r_m_vld;
    logic              r_m_ok;
    logic [CW-1:0]     r_m_x1, r_m_y1;
    logic              r_m_nx, r_m_ny;
    logic [PW-1:0]     r_m_prod [0:NB-1];   // start x, start y, end x, end y

    always_ff @(posedge i_clk) begin
        logic [MW-1:0] adx, ady;
        logic [F:0]    ut0, ut1;
        adx = r_c2_meta.dx[MW-1] ? MW'(-r_c2_meta.dx) : MW'(r_c2_meta.dx);
        ady = r_c2_meta.dy[MW-1] ? MW'(-r_c2_meta.dy) : MW'(r_c2_meta.dy);
        ut0 = r_c2_w.t0[F:0];
        ut1 = r_c2_w.t1[F:0];
        r_m_ok      <= r_c2_w.ok;
        r_m_x1      <= r_c2_meta.x1;
        r_m_y1      <= r_c2_meta.y1;
        r_m_nx      <= r_c2_meta.dx[MW-1];
        r_m_ny      <= r_c2_meta.dy[MW-1];
        r_m_prod[0] <= PW'(ut0) * PW'(adx);
        r_m_prod[1] <= PW'(ut0) * PW'(ady);
        r_m_prod[2] <= PW'(ut1) * PW'(adx);
        r_m_prod[3] <= PW'(ut1) * PW'(ady);
    end

    // ------------------------------------------------------------------
    // Stage O: round to nearest, add to start point, zero on reject
    // ------------------------------------------------------------------
    function automatic logic [CW-1:0] round_add(input logic [CW-1:0] base,
                                                input logic neg,
                                                input logic [PW-1:0] prod);
        logic [PW-1:0] sum;
        logic [CW-1:0] off;
        sum = prod + P_HALF;
        off = CW'(sum >> F);
        return neg ? base - off : base + off;
    endfunction

    always_ff @(posedge i_clk) begin
        o_visible      <= r_m_ok;
        o_clip_start_x <= r_m_ok ? round_add(r_m_x1, r_m_nx, r_m_prod[0]) : '0;
        o_clip_start_y <= r_m_ok ? round_add(r_m_y1, r_m_ny, r_m_prod[1]) : '0;
        o_clip_end_x   <= r_m_ok ? round_add(r_m_x1, r_m_nx, r_m_prod[2]) : '0;
        o_clip_end_y   <= r_m_ok ? round_add(r_m_y1, r_m_ny, r_m_prod[3]) : '0;
    end

    // ------------------------------------------------------------------
    // Valid bits travel with the data
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_d_vld  <= '0;
            r_t_vld  <= 1'b0;
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_m_vld  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_a_vld  <= start && !busy;
            r_d_vld  <= {r_d_vld[F-1:0], r_a_vld};
            r_t_vld  <= r_d_vld[F];
            r_c1_vld <= r_t_vld;
            r_c2_vld <= r_c1_vld;
            r_m_vld  <= r_c2_vld;
            o_valid  <= r_m_vld;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // rejected results carry zero coordinates
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_clip_start_x == '0 && o_clip_start_y == '0 &&
                                     o_clip_end_x == '0 && o_clip_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

    // a kept segment has its entry parameter not past its exit parameter
    a_t_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c2_vld && r_c2_w.ok) |-> (r_c2_w.t0 <= r_c2_w.t1 && r_c2_w.t0 >= 0 &&
                                    r_c2_w.t1 <= T_ONE))
        else $error("entry/exit parameters out of order or range");

    // each result strobe follows a multiply-stage item in the cycle before
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_m_vld))
        else $error("result strobe without an item in flight");

endmodule

`default_nettype wire
